/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files, included by ese_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ESE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ESE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/ese_pkg.sv */
`default_nettype none
package ese_pkg;

  // Default number of entries in the composite mark store.
  localparam int unsigned ESE_MAX_ENTRIES = 65536;

  // Width of every number handled by the block.
  localparam int unsigned NUM_W = 16;

  localparam logic [NUM_W-1:0] NUM_MAX   = 16'hFFFF;
  localparam logic [NUM_W-1:0] NUM_TWO   = 16'd2;
  localparam logic [NUM_W-1:0] NUM_THREE = 16'd3;

  // Word index of the limit register on the configuration port.
  localparam logic REG_MAX_NUMBER = 1'b0;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_FIND  = 2'd2
  } act_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SQUARE,
    ST_MARK,
    ST_FIND,
    ST_SCAN,
    ST_DONE
  } st_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    ALU_ADD,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [NUM_W:0]   a;
    logic [NUM_W-1:0] b;
    logic [NUM_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [2*NUM_W:0] value;
    logic             le;
  } alu_res_t;

  // Mark store access of one cycle.
  typedef struct packed {
    logic we;
    logic wdata;
    logic re;
  } mem_req_t;

endpackage
`default_nettype wire

/* hw/rtl/ese_alu.sv */
`default_nettype none
module ese_alu (
  input  var ese_pkg::alu_req_t req,
  output var ese_pkg::alu_res_t res
);
  import ese_pkg::*;

  logic [2*NUM_W:0] value;

  // One adder or one 17x16 multiplier, followed by the compare against the limit.
  always_comb begin
    unique case (req.op)
      ALU_MUL: value = (2*NUM_W+1)'(req.a) * (2*NUM_W+1)'(req.b);
      ALU_ADD: value = (2*NUM_W+1)'(req.a) + (2*NUM_W+1)'(req.b);
      default: value = '0;
    endcase
  end

  assign res.value = value;
  assign res.le    = (value <= (2*NUM_W+1)'(req.lim));

endmodule
`default_nettype wire

/* hw/rtl/ese_mark_ram.sv */
`default_nettype none
module ese_mark_ram #(
  parameter int unsigned DEPTH = ese_pkg::ESE_MAX_ENTRIES,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic           clk,
  input  wire logic [AW-1:0]  addr,
  input  var ese_pkg::mem_req_t req,
  output logic                rdata
);
  import ese_pkg::*;

  logic mem [DEPTH];

  // Single port at one address: one write, one registered read, or both, per cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ese_seq.sv */
`default_nettype none
`include "assert_macros.svh"
module ese_seq #(
  parameter int unsigned MAX_ENTRIES = ese_pkg::ESE_MAX_ENTRIES,
  parameter int unsigned AW          = $clog2(MAX_ENTRIES)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [ese_pkg::NUM_W-1:0] max_number,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                action,
  input  wire logic [ese_pkg::NUM_W-1:0] prime,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [ese_pkg::NUM_W-1:0]      found_prime,
  output logic                           bad_prime,
  output logic [AW-1:0]                  mem_addr,
  output ese_pkg::mem_req_t              mem_req,
  input  wire logic                      mem_rdata,
  output ese_pkg::alu_req_t              alu_req,
  input  var ese_pkg::alu_res_t          alu_res
);
  import ese_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);
  localparam logic [NUM_W-1:0] LIM_CAP =
    NUM_W'(((MAX_ENTRIES - 1) > 65535) ? 65535 : (MAX_ENTRIES - 1));

  st_t              state, state_next;
  logic [NUM_W:0]   cur, cur_next;
  logic [AW-1:0]    sweep_cnt, sweep_cnt_next;
  logic [NUM_W-1:0] p_reg, p_reg_next;
  logic [NUM_W-1:0] last_pushed, last_pushed_next;
  logic [NUM_W-1:0] res_prime, res_prime_next;
  logic             res_bad, res_bad_next;
  logic [NUM_W-1:0] lim;
  logic             out_load;

  // Effective limit: the register clamped to the store.
  assign lim = (max_number > LIM_CAP) ? LIM_CAP : max_number;

  assign in_stall = (state != ST_IDLE);

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      sweep_cnt   <= '0;
      last_pushed <= '0;
    end else begin
      state       <= state_next;
      sweep_cnt   <= sweep_cnt_next;
      last_pushed <= last_pushed_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    p_reg     <= p_reg_next;
    res_prime <= res_prime_next;
    res_bad   <= res_bad_next;
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found_prime <= res_prime;
      bad_prime   <= res_bad;
    end
  end

  // Sequencer: next state, store accesses and the use of the shared unit.
  always_comb begin
    state_next       = state;
    cur_next         = cur;
    sweep_cnt_next   = sweep_cnt;
    p_reg_next       = p_reg;
    last_pushed_next = last_pushed;
    res_prime_next   = res_prime;
    res_bad_next     = res_bad;
    out_load         = 1'b0;
    mem_addr         = AW'(cur);
    mem_req          = '0;
    alu_req.op       = ALU_ADD;
    alu_req.a        = cur;
    alu_req.b        = NUM_TWO;
    alu_req.lim      = lim;

    unique case (state)
      ST_INIT, ST_CLEAR: begin
        // Zero one store entry per cycle.
        mem_addr      = sweep_cnt;
        mem_req.we    = 1'b1;
        mem_req.wdata = 1'b0;
        if (sweep_cnt == LAST_IDX) begin
          sweep_cnt_next = '0;
          state_next     = (state == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          sweep_cnt_next = sweep_cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          p_reg_next     = prime;
          res_prime_next = '0;
          res_bad_next   = 1'b0;
          unique case (action)
            ACT_CLEAR: begin
              last_pushed_next = '0;
              state_next       = ST_CLEAR;
            end
            ACT_PUSH: begin
              if (prime < NUM_TWO || prime > lim) begin
                res_bad_next = 1'b1;
                state_next   = ST_DONE;
              end else begin
                last_pushed_next = prime;
                state_next       = ST_SQUARE;
              end
            end
            ACT_FIND: begin
              state_next = ST_FIND;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_SQUARE: begin
        // Marking starts at the square when it lies within the limit.
        alu_req.op = ALU_MUL;
        alu_req.a  = (NUM_W+1)'(p_reg);
        alu_req.b  = p_reg;
        if (alu_res.le) begin
          cur_next   = alu_res.value[NUM_W:0];
          state_next = ST_MARK;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_MARK: begin
        // Mark the current multiple and step to the next one.
        mem_req.we    = 1'b1;
        mem_req.wdata = 1'b1;
        alu_req.b     = p_reg;
        if (alu_res.le) begin
          cur_next = alu_res.value[NUM_W:0];
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_FIND: begin
        alu_req.a = (NUM_W+1)'(last_pushed);
        if (last_pushed == NUM_TWO) begin
          res_prime_next = (lim >= NUM_THREE) ? NUM_THREE : '0;
          state_next     = ST_DONE;
        end else if (alu_res.le) begin
          cur_next   = alu_res.value[NUM_W:0];
          mem_addr   = AW'(alu_res.value[NUM_W:0]);
          mem_req.re = 1'b1;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_SCAN: begin
        // The read data is the mark of the current candidate.
        if (!mem_rdata) begin
          res_prime_next = cur[NUM_W-1:0];
          state_next     = ST_DONE;
        end else if (alu_res.le) begin
          cur_next   = alu_res.value[NUM_W:0];
          mem_addr   = AW'(alu_res.value[NUM_W:0]);
          mem_req.re = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ESE_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall,
    "block took a transfer but did not go busy")
  `ESE_ASSERT(a_mark_in_range, (state == ST_MARK) |-> (cur <= (NUM_W+1)'(lim)),
    "marking beyond the limit")
  `ESE_ASSERT(a_write_states,
    mem_req.we |-> (state == ST_INIT || state == ST_CLEAR || state == ST_MARK),
    "store written outside a sweep or mark pass")
  `ESE_ASSERT_ALWAYS(a_bad_no_prime, (out_valid && bad_prime) |-> (found_prime == '0),
    "rejected push returned a number")

endmodule
`default_nettype wire

/* hw/rtl/eratosthenes_sieve_engine_top.sv */
`default_nettype none
// Channel   Handshake              Payload
// in        in_valid / in_stall    action[1:0], prime[15:0]
// out       out_valid / out_stall  found_prime[15:0], bad_prime
// apb       psel / penable         paddr[2:0], pwdata, prdata (max_number at 0x0)
//
// After reset a clearing pass zeroes the mark store, with in_stall high.
// A clear item zeroes the store again, one store write per cycle.
// A push marks each multiple from its square up to the limit.
// A find reads candidates in steps of two above the last pushed number from the store's single read port.
// A rejected push or an unused action needs no store access. A finished result waits
// in the output register while out_stall is high, and the next item is taken meanwhile.
module eratosthenes_sieve_engine_top #(
  parameter int unsigned MAX_ENTRIES = ese_pkg::ESE_MAX_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                action,
  input  wire logic [ese_pkg::NUM_W-1:0] prime,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [ese_pkg::NUM_W-1:0]      found_prime,
  output logic                           bad_prime,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ese_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  logic [NUM_W-1:0] max_number;
  logic [AW-1:0]    mem_addr;
  mem_req_t         mem_req;
  logic             mem_rdata;
  alu_req_t         alu_req;
  alu_res_t         alu_res;

  // Configuration register, written in the access phase of a transfer.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_number <= NUM_MAX;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_NUMBER) begin
      max_number <= pwdata[NUM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_NUMBER) ? 32'(max_number) : '0;

  ese_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ese_mark_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .addr  (mem_addr),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ese_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .max_number  (max_number),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .prime       (prime),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found_prime (found_prime),
    .bad_prime   (bad_prime),
    .mem_addr    (mem_addr),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .alu_req     (alu_req),
    .alu_res     (alu_res)
  );

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ese_pkg::*;

  // Action code outside the defined set; the block answers it with zeros.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Cycles allowed after the last answer before a register write or the end.
  localparam int SETTLE_CYCLES = 64;
  // Normal runs spend most of their time in clear passes.
  localparam int CYCLE_LIMIT = 6000000;
  localparam int RANDOM_ITEMS_PER_PHASE = 18;

  typedef struct {
    logic [1:0]       act;
    logic [NUM_W-1:0] num;
  } sieve_item_t;

  typedef struct {
    logic [NUM_W-1:0] nxt;
    logic             bad;
  } sieve_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid = 1'b0;
  wire logic        in_stall;
  logic [1:0]       action = ACT_CLEAR;
  logic [NUM_W-1:0] prime = '0;
  wire logic        out_valid;
  logic             out_stall = 1'b0;
  wire logic [NUM_W-1:0] found_prime;
  wire logic        bad_prime;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  wire logic [31:0] prdata;
  wire logic        pready;

  sieve_item_t   pending_items[$];
  sieve_answer_t sieve_answers[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // Shadow copy of the block state.
  bit               composite_shadow[ESE_MAX_ENTRIES];
  logic [NUM_W-1:0] last_prime_shadow = '0;
  logic [NUM_W-1:0] limit_shadow = NUM_MAX;

  eratosthenes_sieve_engine_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .prime       (prime),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found_prime (found_prime),
    .bad_prime   (bad_prime),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one item to the shadow state and returns the answer it yields.
  function automatic void sieve_apply(input logic [1:0] act, input logic [NUM_W-1:0] num,
                                      output logic [NUM_W-1:0] nxt, output logic bad);
    longint lim;
    longint p;
    longint i;
    bit     found;
    lim = limit_shadow;
    if (lim > ESE_MAX_ENTRIES - 1) lim = ESE_MAX_ENTRIES - 1;
    nxt = '0;
    bad = 1'b0;
    found = 1'b0;
    case (act)
      ACT_CLEAR: begin
        for (i = 0; i < ESE_MAX_ENTRIES; i++) composite_shadow[i] = 1'b0;
        last_prime_shadow = '0;
      end
      ACT_PUSH: begin
        p = num;
        if (p < 2 || p > lim) begin
          bad = 1'b1;
        end else begin
          last_prime_shadow = num;
          // Cross off multiples from the square upward.
          if (p * p <= lim) begin
            for (i = p * p; i <= lim; i += p) composite_shadow[i] = 1'b1;
          end
        end
      end
      ACT_FIND: begin
        if (last_prime_shadow == NUM_TWO) begin
          nxt = (lim >= 3) ? NUM_THREE : '0;
        end else begin
          // Candidates after the last prime are scanned in steps of two.
          for (i = longint'(last_prime_shadow) + 2; i <= lim && !found; i += 2) begin
            if (!composite_shadow[i]) begin
              nxt = i[NUM_W-1:0];
              found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit is_prime(input int n);
    int d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int prime_after(input int n);
    int c;
    c = n + 1;
    while (!is_prime(c)) c++;
    return c;
  endfunction

  // Input driver: predicts each transfer and presents the next pending item.
  always @(posedge clk) begin
    logic [NUM_W-1:0] nxt;
    logic             bad;
    sieve_item_t      item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sieve_apply(action, prime, nxt, bad);
        sieve_answers.push_back('{nxt: nxt, bad: bad});
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = pending_items.pop_front();
          in_valid <= 1'b1;
          action <= item.act;
          prime <= item.num;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output monitor: each transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    sieve_answer_t exp_ans;
    if (!rst && out_valid && !out_stall) begin
      if (sieve_answers.size() == 0) begin
        $error("unexpected result: found_prime %0d, bad_prime %0d", found_prime, bad_prime);
        fail_count++;
      end else begin
        exp_ans = sieve_answers.pop_front();
        if (found_prime !== exp_ans.nxt) begin
          $error("found_prime mismatch: expected %0d, actual %0d", exp_ans.nxt, found_prime);
          fail_count++;
        end
        if (bad_prime !== exp_ans.bad) begin
          $error("bad_prime mismatch: expected %0d, actual %0d", exp_ans.bad, bad_prime);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] act, input logic [NUM_W-1:0] num);
    pending_items.push_back('{act: act, num: num});
  endtask

  // Waits until every item has been sent and every answer has come back.
  task automatic wait_until_idle();
    while (pending_items.size() != 0 || in_valid || sieve_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the limit register; upper data bits are don't-care and randomized.
  task automatic write_limit(input logic [NUM_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_NUMBER, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_shadow = value;
  endtask

  // One random phase: mostly an in-order sieve walk, with noise mixed in.
  task automatic random_phase(input int send_pct, input int recv_pct,
                              input logic [NUM_W-1:0] lim);
    int count;
    int walk_prime;
    int r;
    wait_until_idle();
    write_limit(lim);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_item(ACT_CLEAR, 16'($urandom));
    walk_prime = 2;
    count = 0;
    while (count < RANDOM_ITEMS_PER_PHASE) begin
      r = $urandom_range(99);
      if (r < 70) begin
        add_item(ACT_FIND, 16'($urandom));
        add_item(ACT_PUSH, walk_prime[NUM_W-1:0]);
        walk_prime = prime_after(walk_prime);
        count += 2;
      end else begin
        if (r < 80) begin
          add_item(ACT_PUSH, 16'($urandom));
        end else if (r < 88) begin
          add_item(ACT_PUSH, 16'($urandom_range(int'(lim) + 8)));
        end else if (r < 94) begin
          add_item(ACT_FIND, 16'($urandom));
        end else if (r < 98) begin
          add_item(ACT_UNUSED, 16'($urandom));
        end else begin
          add_item(ACT_CLEAR, 16'($urandom));
          walk_prime = 2;
        end
        count++;
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the full limit.
    add_item(ACT_FIND, '0);
    add_item(ACT_PUSH, 16'd0);
    add_item(ACT_PUSH, 16'd1);
    add_item(ACT_PUSH, NUM_TWO);
    add_item(ACT_FIND, '0);
    add_item(ACT_PUSH, NUM_THREE);
    add_item(ACT_FIND, NUM_MAX);
    add_item(ACT_UNUSED, NUM_MAX);
    add_item(ACT_PUSH, NUM_MAX);
    add_item(ACT_FIND, '0);
    add_item(ACT_PUSH, 16'hFFFD);
    add_item(ACT_FIND, '0);
    add_item(ACT_CLEAR, NUM_MAX);
    add_item(ACT_FIND, '0);

    // A limit of two leaves no room for three after two.
    wait_until_idle();
    write_limit(16'd2);
    add_item(ACT_PUSH, NUM_TWO);
    add_item(ACT_FIND, '0);
    add_item(ACT_PUSH, NUM_THREE);

    // Limits below two reject every push and find nothing; a limit of three then finds three.
    wait_until_idle();
    write_limit(16'd0);
    add_item(ACT_PUSH, NUM_TWO);
    add_item(ACT_FIND, '0);
    wait_until_idle();
    write_limit(16'd1);
    add_item(ACT_PUSH, 16'd0);
    add_item(ACT_FIND, '0);
    wait_until_idle();
    write_limit(16'd3);
    add_item(ACT_FIND, '0);

    // Changing the limit keeps the marks; a last prime beyond it finds nothing.
    wait_until_idle();
    write_limit(16'd50);
    add_item(ACT_PUSH, 16'd7);
    wait_until_idle();
    write_limit(16'd40);
    add_item(ACT_PUSH, NUM_TWO);
    add_item(ACT_PUSH, 16'd37);
    wait_until_idle();
    write_limit(16'd30);
    add_item(ACT_FIND, '0);

    // Random phases under different idling patterns.
    random_phase(0, 0, 16'($urandom_range(600, 100)));
    random_phase(61, 0, 16'($urandom_range(600, 100)));
    random_phase(0, 61, 16'($urandom_range(600, 100)));
    random_phase(38, 38, NUM_MAX);

    wait_until_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
